FILE: rtl/idmca_pkg.sv
package idmca_pkg;

  localparam int FRAC_BITS = 8;
  localparam int QB        = 16;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 24;

  typedef enum logic [CFG_AW-1:0] {
    REG_MAX_ACCEL      = 3'd0,
    REG_COMFORT_DECEL  = 3'd1,
    REG_DESIRED_SPEED  = 3'd2,
    REG_ACCEL_EXPONENT = 3'd3,
    REG_MIN_GAP        = 3'd4,
    REG_TIME_HEADWAY   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] v;
    logic [15:0] s;
    logic        dvneg;
  } ctx_t;

  localparam logic [OUT_W-1:0] ACCEL_MIN = 24'h800000;
  localparam logic [OUT_W-1:0] ACCEL_MAX = 24'h7FFFFF;

endpackage

FILE: rtl/idm_car_following_accel.sv
// The pipeline has 110 stages; m_tvalid is the valid bit of the last one.
// Throughput: one item per cycle while s_tready is high; the whole pipeline holds
// while the output item is not taken. The depth is set by the bit-per-stage dividers
// of the interaction term. After reset and after every register write, s_tready
// stays low while sqrt(a*b) is recomputed by a one-bit-per-cycle root unit.
// Reset is synchronous: registers return to their defaults, pipeline valid bits clear.
module idm_car_following_accel
  import idmca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // speed[15:0], approach_rate[31:16], gap[47:32]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // accel[23:0]
  output logic              m_tuser,   // saturated[0]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int L     = 110;
  localparam int NR    = 32;
  localparam int MR    = 16;
  localparam int NY    = 55;
  localparam int MY    = 21;
  localparam int NG    = 48;
  localparam int MG    = 16;
  localparam int ST_R0 = 61;
  localparam int ST_G0 = 57;
  localparam int ST_TQ = 56;
  localparam int ST_TV = 52;
  localparam int ST_IM = 108;
  localparam int NPOW  = 7;
  localparam int SHR   = QB - FRAC_BITS;
  localparam int RECIP_SH = 44;

  localparam logic [37:0]   RECIP_125    = 38'd140737488356;
  localparam logic [40:0]   LOSS_CAP     = 41'(1) << 40;
  localparam logic [72:0]   POW_LIMIT    = 73'(1) << 56;

  logic [11:0] max_accel;
  logic [11:0] comfort_decel;
  logic [15:0] desired_speed;
  logic [3:0]  accel_exponent;
  logic [15:0] min_gap;
  logic [13:0] time_headway;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel      <= 12'd100;
      comfort_decel  <= 12'd150;
      desired_speed  <= 16'd3000;
      accel_exponent <= 4'd4;
      min_gap        <= 16'd200;
      time_headway   <= 14'd1500;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MAX_ACCEL:      max_accel      <= cfg_wdata[11:0];
        REG_COMFORT_DECEL:  comfort_decel  <= cfg_wdata[11:0];
        REG_DESIRED_SPEED:  desired_speed  <= cfg_wdata;
        REG_ACCEL_EXPONENT: accel_exponent <= cfg_wdata[3:0];
        REG_MIN_GAP:        min_gap        <= cfg_wdata;
        REG_TIME_HEADWAY:   time_headway   <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  logic [15:0] v0_eff;
  logic [3:0]  d_eff;
  assign v0_eff = (desired_speed == 16'd0) ? 16'd1 : desired_speed;
  assign d_eff  = (accel_exponent == 4'd0) ? 4'd1 :
                  (accel_exponent > 4'd8)  ? 4'd8 : accel_exponent;

  // sqrt(a*b*2^16), one result bit per cycle
  logic        sq_load;
  logic [39:0] sq_x;
  logic [39:0] sq_res;
  logic [39:0] sq_bit;
  logic [23:0] ab_raw;
  logic [39:0] sq_sum;
  logic        busy;

  assign ab_raw = 24'(max_accel) * 24'(comfort_decel);
  assign sq_sum = sq_res + sq_bit;
  assign busy   = sq_load || (sq_bit != 40'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_load <= 1'b1;
      sq_bit  <= 40'd0;
    end else if (cfg_we) begin
      sq_load <= 1'b1;
      sq_bit  <= 40'd0;
    end else if (sq_load) begin
      sq_load <= 1'b0;
      sq_x    <= {((ab_raw == 24'd0) ? 24'd1 : ab_raw), 16'd0};
      sq_res  <= 40'd0;
      sq_bit  <= 40'(1) << 38;
    end else if (sq_bit != 40'd0) begin
      if (sq_x >= sq_sum) begin
        sq_x   <= sq_x - sq_sum;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  logic [MY-1:0] two_sq;
  assign two_sq = {sq_res[19:0], 1'b0};

  // pipeline control
  logic adv;
  logic vld [0:L-1];
  assign adv      = !vld[L-1] || m_tready;
  assign s_tready = adv && !busy;
  assign m_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid && !busy;
      for (int k = 1; k < L; k++) vld[k] <= vld[k-1];
    end
  end

  ctx_t        ctx [0:L-2];
  logic [16:0] dvmag0;
  logic [15:0] in_dv;
  assign in_dv = s_tdata[31:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0].v     <= s_tdata[15:0];
      ctx[0].s     <= s_tdata[47:32];
      ctx[0].dvneg <= in_dv[15];
      dvmag0       <= in_dv[15] ? ({1'b0, ~in_dv} + 17'd1) : {1'b0, in_dv};
      for (int k = 1; k < L-1; k++) ctx[k] <= ctx[k-1];
    end
  end

  // stage 1 product
  logic [30:0] pvd;
  logic [32:0] pvd_full;
  assign pvd_full = 33'(ctx[0].v) * 33'(dvmag0);

  always_ff @(posedge clk) begin
    if (adv) begin
      pvd <= pvd_full[30:0];
    end
  end

  // T*v*2^16 / 1000 = 65*T*v + floor(67*T*v / 125), the last by reciprocal multiplication
  logic [29:0] tv;
  logic [36:0] ty;
  logic [36:0] tv65a;
  logic [36:0] tv65b;
  logic [37:0] pp_ll;
  logic [37:0] pp_lh;
  logic [36:0] pp_hl;
  logic [36:0] pp_hh;
  logic [74:0] pp_sum;
  logic [36:0] tq;

  assign pp_sum = (75'(pp_hh) << 38) + (75'(pp_lh) << 19) + (75'(pp_hl) << 19)
                + 75'(pp_ll);

  always_ff @(posedge clk) begin
    if (adv) begin
      tv    <= 30'(time_headway) * 30'(ctx[ST_TV].v);
      ty    <= 37'(tv) * 37'd67;
      tv65a <= 37'(tv) * 37'd65;
      pp_ll <= 38'(ty[18:0]) * 38'(RECIP_125[18:0]);
      pp_lh <= 38'(ty[18:0]) * 38'(RECIP_125[37:19]);
      pp_hl <= 37'(ty[36:19]) * 37'(RECIP_125[18:0]);
      pp_hh <= 37'(ty[36:19]) * 37'(RECIP_125[37:19]);
      tv65b <= tv65a;
      tq    <= tv65b + 37'(pp_sum[74:RECIP_SH]);
    end
  end

  // v*|dv|*2^24 / (2*sq)
  logic [NY+MY-1:0] wy [1:NY];
  for (genvar k = 0; k < NY; k++) begin : g_div_y
    logic [NY+MY-1:0] cur;
    logic [MY:0]      top;
    logic [MY:0]      dif;
    if (k == 0) begin : g_first
      assign cur = {{MY{1'b0}}, pvd, 24'd0};
    end else begin : g_rest
      assign cur = wy[k];
    end
    assign top = cur[NY+MY-1:NY-1];
    assign dif = top - {1'b0, two_sq};
    always_ff @(posedge clk) begin
      if (adv) begin
        wy[k+1] <= (top >= {1'b0, two_sq}) ? {dif[MY-1:0], cur[NY-2:0], 1'b1}
                                           : {top[MY-1:0], cur[NY-2:0], 1'b0};
      end
    end
  end

  logic [NG-1:0] base;
  logic [NG-1:0] yq;
  logic [NG-1:0] nmag;
  assign base = (NG'(min_gap) << QB) + NG'(tq);
  assign yq   = wy[NY][NG-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctx[ST_TQ].dvneg) begin
        nmag <= (base >= yq) ? (base - yq) : (yq - base);
      end else begin
        nmag <= base + yq;
      end
    end
  end

  // |n| / s
  logic [NG+MG-1:0] wg [1:NG];
  for (genvar k = 0; k < NG; k++) begin : g_div_g
    logic [NG+MG-1:0] cur;
    logic [MG:0]      top;
    logic [MG:0]      dif;
    logic [MG-1:0]    dvs;
    if (k == 0) begin : g_first
      assign cur = {{MG{1'b0}}, nmag};
    end else begin : g_rest
      assign cur = wg[k];
    end
    assign dvs = ctx[ST_G0+k].s;
    assign top = cur[NG+MG-1:NG-1];
    assign dif = top - {1'b0, dvs};
    always_ff @(posedge clk) begin
      if (adv) begin
        wg[k+1] <= (top >= {1'b0, dvs}) ? {dif[MG-1:0], cur[NG-2:0], 1'b1}
                                        : {top[MG-1:0], cur[NG-2:0], 1'b0};
      end
    end
  end

  logic [NG-1:0] gq;
  logic          gbig1;
  logic          gbig2;
  logic [63:0]   gsq;
  logic [59:0]   ima;
  logic [59:0]   imf;
  logic [40:0]   im;
  assign gq  = wg[NG][NG-1:0];
  assign imf = ima >> SHR;

  always_ff @(posedge clk) begin
    if (adv) begin
      gbig1 <= gq[NG-1:32] != 16'd0;
      gsq   <= 64'(gq[31:0]) * 64'(gq[31:0]);
      gbig2 <= gbig1;
      ima   <= 60'(gsq[63:16]) * 60'(max_accel);
      im    <= (gbig2 || (imf > 60'(LOSS_CAP))) ? LOSS_CAP : imf[40:0];
    end
  end

  // v*2^16 / v0
  logic [NR+MR-1:0] wr [1:NR];
  for (genvar k = 0; k < NR; k++) begin : g_div_r
    logic [NR+MR-1:0] cur;
    logic [MR:0]      top;
    logic [MR:0]      dif;
    if (k == 0) begin : g_first
      assign cur = {{MR{1'b0}}, ctx[ST_R0].v, 16'd0};
    end else begin : g_rest
      assign cur = wr[k];
    end
    assign top = cur[NR+MR-1:NR-1];
    assign dif = top - {1'b0, v0_eff};
    always_ff @(posedge clk) begin
      if (adv) begin
        wr[k+1] <= (top >= {1'b0, v0_eff}) ? {dif[MR-1:0], cur[NR-2:0], 1'b1}
                                           : {top[MR-1:0], cur[NR-2:0], 1'b0};
      end
    end
  end

  logic [NR-1:0] ratio;
  assign ratio = wr[NR][NR-1:0];

  // (v/v0)^delta, two stages per power step
  logic [40:0] pa  [1:NPOW];
  logic [31:0] ra  [1:NPOW];
  logic [56:0] plo [1:NPOW];
  logic [56:0] phi [1:NPOW];
  logic [40:0] pb  [1:NPOW];
  logic [31:0] rb  [1:NPOW];

  for (genvar i = 1; i <= NPOW; i++) begin : g_pow
    logic [40:0] pin;
    logic [31:0] rin;
    logic [56:0] mlo;
    logic [56:0] mhi;
    logic [72:0] prod;
    if (i == 1) begin : g_first
      assign pin = {9'd0, ratio};
      assign rin = ratio;
    end else begin : g_rest
      assign pin = pb[i-1];
      assign rin = rb[i-1];
    end
    assign mlo  = 57'(pin) * 57'(rin[15:0]);
    assign mhi  = 57'(pin) * 57'(rin[31:16]);
    assign prod = {phi[i], 16'd0} + {16'd0, plo[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        pa[i]  <= pin;
        ra[i]  <= rin;
        plo[i] <= mlo;
        phi[i] <= mhi;
        rb[i]  <= ra[i];
        if (4'(i) < d_eff) begin
          pb[i] <= (prod > POW_LIMIT) ? LOSS_CAP : prod[56:16];
        end else begin
          pb[i] <= pa[i];
        end
      end
    end
  end

  logic [52:0] fmf;
  logic [52:0] fm;
  assign fmf = 53'(pb[NPOW]) * 53'(max_accel);

  always_ff @(posedge clk) begin
    if (adv) fm <= fmf >> SHR;
  end

  // combine and clamp
  logic [55:0] accw;
  logic [OUT_W-1:0] acc_out;
  logic             sat_out;
  assign accw = (56'(max_accel) << FRAC_BITS) - 56'(fm) - 56'(im);

  always_comb begin
    if (ctx[ST_IM].s == 16'd0) begin
      acc_out = ACCEL_MIN;
      sat_out = 1'b1;
    end else if ($signed(accw) > 56'sd8388607) begin
      acc_out = ACCEL_MAX;
      sat_out = 1'b1;
    end else if ($signed(accw) < -56'sd8388608) begin
      acc_out = ACCEL_MIN;
      sat_out = 1'b1;
    end else begin
      acc_out = accw[OUT_W-1:0];
      sat_out = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= acc_out;
      m_tuser <= sat_out;
    end
  end

endmodule

FILE: rtl/idmca_check.sv
module idmca_check
  import idmca_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic              m_tuser,
  input logic              cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_sat_rails: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == ACCEL_MIN) || (m_tdata == ACCEL_MAX))
    else $error("saturated item not at a rail");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_cfg_holdoff: assert property (@(posedge clk)
    cfg_we |=> !s_tready)
    else $error("input taken while root is recomputed");

endmodule

bind idm_car_following_accel idmca_check u_check (.*);

FILE: tb/idm_car_following_accel_tb.sv
module idm_car_following_accel_tb;
  import idmca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 140;
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;
  localparam longint unsigned LOSS_CAP = 64'd1 << 40;

  typedef struct packed {
    logic [OUT_W-1:0] accel;
    logic             saturated;
  } accel_result_t;

  class accel_scoreboard;
    longint unsigned a, b, v0, delta, s0, headway;
    accel_result_t   pending_q[$];
    int              errors;
    int              checked;

    function new();
      a = 100; b = 150; v0 = 3000; delta = 4; s0 = 200; headway = 1500;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_MAX_ACCEL:      a = val & 16'h0FFF;
        REG_COMFORT_DECEL:  b = val & 16'h0FFF;
        REG_DESIRED_SPEED:  v0 = val;
        REG_ACCEL_EXPONENT: delta = val & 16'h000F;
        REG_MIN_GAP:        s0 = val;
        REG_TIME_HEADWAY:   headway = val & 16'h3FFF;
        default: ;
      endcase
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function accel_result_t idm_accel(logic [15:0] speed, logic [15:0] rate,
                                      logic [15:0] gap);
      accel_result_t   res;
      longint unsigned v, s, dvm, den, d, r, p, fm, im, ab, sq, dyn, base, nmag, g;
      longint          acc;
      logic            dv_neg;
      v = speed;
      s = gap;
      dv_neg = rate[15];
      dvm = dv_neg ? (((64'(rate) ^ 64'hFFFF) + 64'd1) & 64'h1FFFF) : 64'(rate);
      res.saturated = 1'b0;
      if (s == 0) begin
        res.accel = ACCEL_MIN;
        res.saturated = 1'b1;
        return res;
      end
      den = (v0 == 0) ? 1 : v0;
      d = (delta == 0) ? 1 : ((delta > 8) ? 8 : delta);
      r = (v << QB) / den;
      p = r;
      for (longint unsigned i = 1; i < d; i++) begin
        if (r != 0 && p > (LOSS_CAP << QB) / r) p = LOSS_CAP;
        else p = (p * r) >> QB;
      end
      fm = (p * a) >> (QB - FRAC_BITS);
      ab = a * b;
      if (ab == 0) ab = 1;
      sq = isqrt(ab << QB);
      dyn = ((v * dvm) << 24) / (2 * sq);
      base = (s0 << QB) + ((headway * v) << QB) / 1000;
      if (dv_neg) nmag = (base >= dyn) ? base - dyn : dyn - base;
      else nmag = base + dyn;
      g = nmag / s;
      if (g >= (64'd1 << 32)) begin
        im = LOSS_CAP;
      end else begin
        im = (((g * g) >> QB) * a) >> (QB - FRAC_BITS);
        if (im > LOSS_CAP) im = LOSS_CAP;
      end
      acc = longint'(a << FRAC_BITS) - longint'(fm) - longint'(im);
      if (acc > 64'sd8388607) begin
        acc = 8388607;
        res.saturated = 1'b1;
      end
      if (acc < -64'sd8388608) begin
        acc = -8388608;
        res.saturated = 1'b1;
      end
      res.accel = acc[OUT_W-1:0];
      return res;
    endfunction

    function void note_item(logic [15:0] speed, logic [15:0] rate, logic [15:0] gap);
      pending_q.push_back(idm_accel(speed, rate, gap));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] accel, logic saturated);
      accel_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result accel=%h sat=%b", accel, saturated));
        return;
      end
      want = pending_q.pop_front();
      if (accel !== want.accel)
        report($sformatf("accel got %h want %h", accel, want.accel));
      if (saturated !== want.saturated)
        report($sformatf("saturated got %b want %b", saturated, want.saturated));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  accel_scoreboard sb;
  int  cycles;
  int  items_sent;
  int  settings_run;
  bit  quiet;

  idm_car_following_accel dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  task automatic set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [15:0] a, logic [15:0] b, logic [15:0] v0,
                               logic [15:0] d, logic [15:0] s0, logic [15:0] t);
    set_reg(REG_MAX_ACCEL, a);
    set_reg(REG_COMFORT_DECEL, b);
    set_reg(REG_DESIRED_SPEED, v0);
    set_reg(REG_ACCEL_EXPONENT, d);
    set_reg(REG_MIN_GAP, s0);
    set_reg(REG_TIME_HEADWAY, t);
    settings_run++;
  endtask

  task automatic send_item(logic [15:0] speed, logic [15:0] rate, logic [15:0] gap);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {gap, rate, speed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(speed, rate, gap);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        send_item(16'($urandom_range(0, 4000)),
                  16'($signed($urandom_range(0, 2000)) - 1000),
                  16'($urandom_range(1, 10000)));
      else if (pick < 9)
        send_item(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_item($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                  $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                  16'($urandom_range(0, 2)));
    end
  endtask

  task automatic send_directed();
    send_item(16'd0, 16'd0, 16'd0);
    send_item(16'hFFFF, 16'h8000, 16'd0);
    send_item(16'd0, 16'd0, 16'd1);
    send_item(16'd0, 16'd0, 16'hFFFF);
    send_item(16'hFFFF, 16'h7FFF, 16'd1);
    send_item(16'hFFFF, 16'h8000, 16'hFFFF);
    send_item(16'hFFFF, 16'h0000, 16'hFFFF);
    send_item(16'd3000, 16'h0000, 16'd5000);
    send_item(16'd1500, 16'hFE0C, 16'd800);
    send_item(16'd2500, 16'd300, 16'd2000);
    send_item(16'd100, 16'hFFFF, 16'd50);
    send_item(16'd6000, 16'd0, 16'd65535);
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    settings_run = 1;
    quiet = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_MAX_ACCEL;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed();
    send_random(80);
    drain();

    apply_setting(16'd4095, 16'd4095, 16'hFFFF, 16'd8, 16'hFFFF, 16'd16383);
    send_directed();
    send_random(60);
    drain();

    apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
    send_directed();
    send_random(60);
    drain();

    set_reg(REG_SPARE_LO, 16'hFFFF);
    set_reg(REG_SPARE_HI, 16'h1234);
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd300, 16'd1000);
    send_random(50);
    drain();

    apply_setting(16'd200, 16'd300, 16'd2500, 16'd15, 16'd150, 16'd1200);
    send_random(50);
    drain();

    for (int k = 0; k < 4; k++) begin
      apply_setting(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                    16'($urandom), 16'($urandom_range(0, 15)), 16'($urandom),
                    16'($urandom_range(0, 16383)));
      send_random(50);
      drain();
    end

    apply_setting(16'd150, 16'd200, 16'd3300, 16'd4, 16'd200, 16'd1500);
    quiet = 1'b1;
    send_random(100);
    drain();

    $display("sent %0d items over %0d register settings, %0d results checked",
             items_sent, settings_run, sb.checked);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
